// ===== rtl/pidis_pkg.sv =====
package pidis_pkg;

  // default values of the top-level parameters
  localparam int ADC_BITS_DEF  = 12;
  localparam int DAC_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF = 16;

  // port widths
  localparam int CODE_W    = 12;
  localparam int ERR_OUT_W = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int THR_W     = 31;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REF_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OFFSET = 3'd7;

  // register reset values
  localparam logic [CFG_W-1:0] RST_REF_GAIN   = 32'd56016;
  localparam logic [CFG_W-1:0] RST_FB_GAIN    = 32'd65250;
  localparam logic [CFG_W-1:0] RST_ERR_OFFSET = 32'd4538976;
  localparam logic [CFG_W-1:0] RST_KP         = 32'd655360;
  localparam logic [CFG_W-1:0] RST_KI         = 32'd50397;
  localparam logic [CFG_W-1:0] RST_KD         = 32'd7864320;
  localparam logic [THR_W-1:0] RST_THRESHOLD  = 31'd11163402;
  localparam logic [CFG_W-1:0] RST_OUT_OFFSET = 32'd134204621;

  // control mode codes
  localparam logic [1:0] FUNC_P_ONLY = 2'd0;
  localparam logic [1:0] FUNC_SEP    = 2'd2;
  localparam logic [1:0] FUNC_CLAMP  = 2'd3;

  // clip codes
  localparam logic [1:0] CLIP_NONE = 2'd0;
  localparam logic [1:0] CLIP_HIGH = 2'd1;
  localparam logic [1:0] CLIP_LOW  = 2'd2;

  // operand pair on the shared multiplier
  typedef enum logic [2:0] {
    MUL_REF,
    MUL_FB,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    logic     load_acc;
    logic     load_err;
    logic     load_diff;
    logic     load_pterm;
    logic     load_integ;
    logic     commit;
    logic     load_out;
  } cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== rtl/pidis_ctrl.sv =====
module pidis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pidis_pkg::status_t status,
  output pidis_pkg::cmd_t    cmd
);
  import pidis_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_MUL_REF = 9'b000000010,
    ST_MUL_FB  = 9'b000000100,
    ST_ERR     = 9'b000001000,
    ST_MUL_P   = 9'b000010000,
    ST_MUL_I   = 9'b000100000,
    ST_MUL_D   = 9'b001000000,
    ST_CTRL    = 9'b010000000,
    ST_OUT     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // sequence of one request through the shared multiplier
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MUL_REF;
    in_ready    = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_MUL_REF;
        end
      end
      ST_MUL_REF: begin
        cmd.mul_sel = MUL_REF;
        state_nxt   = ST_MUL_FB;
      end
      ST_MUL_FB: begin
        cmd.mul_sel  = MUL_FB;
        cmd.load_acc = 1'b1;
        state_nxt    = ST_ERR;
      end
      ST_ERR: begin
        cmd.load_err = 1'b1;
        state_nxt    = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.mul_sel   = MUL_P;
        cmd.load_diff = 1'b1;
        state_nxt     = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_sel    = MUL_I;
        cmd.load_pterm = 1'b1;
        state_nxt      = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_sel    = MUL_D;
        cmd.load_integ = 1'b1;
        state_nxt      = ST_CTRL;
      end
      ST_CTRL: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/pidis_dp.sv =====
module pidis_dp #(
  parameter int ADC_BITS  = pidis_pkg::ADC_BITS_DEF,
  parameter int DAC_BITS  = pidis_pkg::DAC_BITS_DEF,
  parameter int FRAC_BITS = pidis_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pidis_pkg::cmd_t                        cmd,
  output pidis_pkg::status_t                     status,
  input  logic                                   cfg_we,
  input  logic [pidis_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidis_pkg::CFG_W-1:0]            cfg_data,
  input  logic [1:0]                             in_func,
  input  logic [2:0]                             in_gain_select,
  input  logic [pidis_pkg::CODE_W-1:0]           in_ref_code,
  input  logic [pidis_pkg::CODE_W-1:0]           in_fb_code,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [pidis_pkg::CODE_W-1:0]           out_drive_code,
  output logic signed [pidis_pkg::ERR_OUT_W-1:0] out_error_value,
  output logic [1:0]                             out_clip
);
  import pidis_pkg::*;

  // p-only gain (184 + g) / 100, rounded, in the fraction format
  function automatic logic signed [31:0] gain_entry(input int g);
    longint v;
    v = ((longint'(184 + g) << FRAC_BITS) + 50) / 100;
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
    logic signed [66:0] hi;
    logic signed [66:0] lo;
    hi = 67'sd2147483647;
    lo = -67'sd2147483648;
    if (x > hi) return 32'sh7fffffff;
    if (x < lo) return 32'sh80000000;
    return 32'(x);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [66:0] x);
    logic signed [66:0] hi;
    logic signed [66:0] lo;
    hi = 67'sh7fffffffffff;
    lo = -67'sh800000000000;
    if (x > hi) return 48'sh7fffffffffff;
    if (x < lo) return 48'sh800000000000;
    return 48'(x);
  endfunction

  localparam logic signed [31:0] GAIN_TAB [8] = '{
    gain_entry(0), gain_entry(1), gain_entry(2), gain_entry(3),
    gain_entry(4), gain_entry(5), gain_entry(6), gain_entry(7)
  };

  localparam int IN_BITS = (ADC_BITS < CODE_W) ? ADC_BITS : CODE_W;
  localparam logic [CODE_W-1:0] ADC_MASK = CODE_W'((longint'(1) << IN_BITS) - 1);
  localparam longint HALF_L  = longint'(1) << (FRAC_BITS - 1);
  localparam longint LIM_L   = ((longint'(1) << (DAC_BITS - 1)) - 1) << FRAC_BITS;
  localparam longint DMAX_L  = (longint'(1) << DAC_BITS) - 1;
  localparam logic signed [47:0] LIM      = 48'(LIM_L);
  localparam logic signed [49:0] HALF     = 50'(HALF_L);
  localparam logic signed [49:0] OUT_HI   = 50'((DMAX_L << FRAC_BITS) - HALF_L);
  localparam logic [CODE_W-1:0]  DRIVE_MAX = CODE_W'(DMAX_L);

  // configuration registers
  logic signed [31:0] ref_gain_r, fb_gain_r, err_offset_r;
  logic signed [31:0] kp_r, ki_r, kd_r, out_offset_r;
  logic [THR_W-1:0]   thr_r;

  // captured request
  logic [1:0]        func_r;
  logic [2:0]        gsel_r;
  logic [CODE_W-1:0] rc_r, fc_r;

  // working registers
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_nxt, prod_r, qprod;
  logic signed [63:0] acc_r;
  logic signed [65:0] err_sum;
  logic signed [31:0] e_r, diff_r;
  logic signed [47:0] integ_new_r, integ_nxt, ctrl_r, ctrl_nxt;

  // controller state
  logic signed [31:0] prev_error_r;
  logic signed [47:0] integral_r, last_ctrl_r;

  // integration decision
  logic signed [33:0] thr_s;
  logic               sep_skip, clamp_skip, do_add;

  // output stage
  logic signed [49:0]          outv;
  logic signed [31:0]          ev_full;
  logic [CODE_W-1:0]           drive_nxt, drive_r;
  logic signed [ERR_OUT_W-1:0] ev_nxt, ev_r;
  logic [1:0]                  clip_nxt, clip_r;
  logic                        out_valid_r, out_valid_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_gain_r   <= RST_REF_GAIN;
      fb_gain_r    <= RST_FB_GAIN;
      err_offset_r <= RST_ERR_OFFSET;
      kp_r         <= RST_KP;
      ki_r         <= RST_KI;
      kd_r         <= RST_KD;
      thr_r        <= RST_THRESHOLD;
      out_offset_r <= RST_OUT_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_GAIN:   ref_gain_r   <= cfg_data;
        REG_FB_GAIN:    fb_gain_r    <= cfg_data;
        REG_ERR_OFFSET: err_offset_r <= cfg_data;
        REG_KP:         kp_r         <= cfg_data;
        REG_KI:         ki_r         <= cfg_data;
        REG_KD:         kd_r         <= cfg_data;
        REG_THRESHOLD:  thr_r        <= cfg_data[THR_W-1:0];
        REG_OUT_OFFSET: out_offset_r <= cfg_data;
      endcase
    end
  end

  // request capture, upper converter bits dropped
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      gsel_r <= in_gain_select;
      rc_r   <= in_ref_code & ADC_MASK;
      fc_r   <= in_fb_code & ADC_MASK;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = ref_gain_r;
    mul_b = signed'({{(32-CODE_W){1'b0}}, rc_r});
    unique case (cmd.mul_sel)
      MUL_REF: begin
        mul_a = ref_gain_r;
        mul_b = signed'({{(32-CODE_W){1'b0}}, rc_r});
      end
      MUL_FB: begin
        mul_a = fb_gain_r;
        mul_b = signed'({{(32-CODE_W){1'b0}}, fc_r});
      end
      MUL_P: begin
        mul_a = (func_r == FUNC_P_ONLY) ? GAIN_TAB[gsel_r] : kp_r;
        mul_b = e_r;
      end
      MUL_I: begin
        mul_a = ki_r;
        mul_b = e_r;
      end
      MUL_D: begin
        mul_a = kd_r;
        mul_b = diff_r;
      end
      default: begin
        mul_a = ref_gain_r;
        mul_b = e_r;
      end
    endcase
  end

  assign prod_nxt = 64'(mul_a) * 64'(mul_b);
  assign qprod    = prod_r >>> FRAC_BITS;

  // error sum from the two scaled codes
  assign err_sum = 66'(acc_r) - 66'(prod_r) + 66'(err_offset_r);

  // integration decision and new integral
  assign thr_s      = signed'({3'b000, thr_r});
  assign sep_skip   = (34'(e_r) > thr_s) || (34'(e_r) < -thr_s);
  assign clamp_skip = ((last_ctrl_r >= LIM) && (e_r > 32'sd0)) ||
                      ((last_ctrl_r <= -LIM) && (e_r < 32'sd0));
  assign do_add     = !((func_r == FUNC_SEP) && sep_skip) &&
                      !((func_r == FUNC_CLAMP) && clamp_skip);

  always_comb begin
    if (func_r == FUNC_P_ONLY) begin
      integ_nxt = '0;
    end else if (do_add) begin
      integ_nxt = sat48(67'(integral_r) + 67'(qprod));
    end else begin
      integ_nxt = integral_r;
    end
  end

  // control value: p term plus integral plus d term, p term alone in p-only mode
  always_comb begin
    if (func_r == FUNC_P_ONLY) begin
      ctrl_nxt = sat48(67'(acc_r));
    end else begin
      ctrl_nxt = sat48(67'(acc_r) + 67'(integ_new_r) + 67'(qprod));
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load_acc) begin
      acc_r <= prod_r;
    end else if (cmd.load_pterm) begin
      acc_r <= qprod;
    end
    if (cmd.load_err) begin
      e_r <= sat32(67'(err_sum));
    end
    if (cmd.load_diff) begin
      diff_r <= sat32(67'(e_r) - 67'(prev_error_r));
    end
    if (cmd.load_integ) begin
      integ_new_r <= integ_nxt;
    end
    if (cmd.commit) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  // controller state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
      integral_r   <= '0;
      last_ctrl_r  <= '0;
    end else if (cmd.commit) begin
      prev_error_r <= e_r;
      integral_r   <= integ_new_r;
      last_ctrl_r  <= ctrl_nxt;
    end
  end

  // offset, round and saturate to a converter code
  assign outv    = 50'(ctrl_r) + 50'(out_offset_r);
  assign ev_full = e_r >>> FRAC_BITS;

  always_comb begin
    if (outv > OUT_HI) begin
      drive_nxt = DRIVE_MAX;
      clip_nxt  = CLIP_HIGH;
    end else if (outv < HALF) begin
      drive_nxt = '0;
      clip_nxt  = CLIP_LOW;
    end else begin
      drive_nxt = CODE_W'((outv + HALF) >>> FRAC_BITS);
      clip_nxt  = CLIP_NONE;
    end
    if (ev_full > 32'sd32767) begin
      ev_nxt = 16'sh7fff;
    end else if (ev_full < -32'sd32768) begin
      ev_nxt = 16'sh8000;
    end else begin
      ev_nxt = ERR_OUT_W'(ev_full);
    end
  end

  // output register
  assign status.out_free = !out_valid_r || out_ready;

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      drive_r <= drive_nxt;
      ev_r    <= ev_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_code  = drive_r;
  assign out_error_value = ev_r;
  assign out_clip        = clip_r;

endmodule

// ===== rtl/pid_with_integral_separation.sv =====
// Positional PID controller with integral separation and clamped integration.
// Each request carries a reference and a feedback converter code; the block
// forms the error ref_gain*ref - fb_gain*fb + error_offset, runs the mode
// chosen by func (p-only from a fixed 1.84..1.91 gain table, plain PID,
// integration skipped above integral_threshold or held while the last control
// value sits at the clamp level and the error pushes further), adds
// output_offset and returns a rounded, saturated drive code with the
// saturated error and a clip flag. All products go through one 32x32
// multiplier in turn, so the next request is accepted the cycle after the
// result register is written; a waiting result stalls only the final write
// of the following result, not acceptance. Configuration registers are
// written with cfg_we while no request is in flight (user rule, unenforced).
module pid_with_integral_separation #(
  parameter int ADC_BITS  = pidis_pkg::ADC_BITS_DEF,
  parameter int DAC_BITS  = pidis_pkg::DAC_BITS_DEF,
  parameter int FRAC_BITS = pidis_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [pidis_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pidis_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_func,
  input  logic [2:0]                             in_gain_select,
  input  logic [pidis_pkg::CODE_W-1:0]           in_ref_code,
  input  logic [pidis_pkg::CODE_W-1:0]           in_fb_code,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [pidis_pkg::CODE_W-1:0]           out_drive_code,
  output logic signed [pidis_pkg::ERR_OUT_W-1:0] out_error_value,
  output logic [1:0]                             out_clip
);
  import pidis_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  pidis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, state and result register
  pidis_dp #(
    .ADC_BITS  (ADC_BITS),
    .DAC_BITS  (DAC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_func         (in_func),
    .in_gain_select  (in_gain_select),
    .in_ref_code     (in_ref_code),
    .in_fb_code      (in_fb_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_drive_code  (out_drive_code),
    .out_error_value (out_error_value),
    .out_clip        (out_clip)
  );

endmodule

// ===== tb/sv/pid_with_integral_separation_test.sv =====
`timescale 1ns / 100ps

module pid_with_integral_separation_test;
  import pidis_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) <<< FRAC;
  localparam longint HALF = ONE >>> 1;
  localparam longint CODE_MAX = (longint'(1) <<< DAC_BITS_DEF) - 1;
  localparam longint CLAMP_CODE = (longint'(1) <<< (DAC_BITS_DEF - 1)) - 1;
  localparam logic [1:0] FUNC_PID = 2'd1;
  localparam logic [CFG_W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [CFG_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [CFG_W-1:0] Q_MIN = 32'h8000_0000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [CODE_W-1:0]           drive;
    logic signed [ERR_OUT_W-1:0] err;
    logic [1:0]                  clip;
  } drive_result_t;

  typedef struct packed {
    logic [CFG_W-1:0] ref_gain;
    logic [CFG_W-1:0] fb_gain;
    logic [CFG_W-1:0] err_offset;
    logic [CFG_W-1:0] kp;
    logic [CFG_W-1:0] ki;
    logic [CFG_W-1:0] kd;
    logic [CFG_W-1:0] threshold;
    logic [CFG_W-1:0] out_offset;
  } gain_set_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic [2:0] in_gain_select = '0;
  logic [CODE_W-1:0] in_ref_code = '0;
  logic [CODE_W-1:0] in_fb_code = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CODE_W-1:0] out_drive_code;
  logic signed [ERR_OUT_W-1:0] out_error_value;
  logic [1:0] out_clip;

  // controller settings as the block should hold them
  logic [CFG_W-1:0] gain_ref = RST_REF_GAIN;
  logic [CFG_W-1:0] gain_fb = RST_FB_GAIN;
  logic [CFG_W-1:0] err_bias = RST_ERR_OFFSET;
  logic [CFG_W-1:0] gain_p = RST_KP;
  logic [CFG_W-1:0] gain_i = RST_KI;
  logic [CFG_W-1:0] gain_d = RST_KD;
  logic [THR_W-1:0] sep_limit = RST_THRESHOLD;
  logic [CFG_W-1:0] drive_bias = RST_OUT_OFFSET;

  // controller history
  longint prev_err_q = 0;
  longint integ_acc = 0;
  longint last_ctrl = 0;

  drive_result_t drive_expected[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  pid_with_integral_separation dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp_signed(longint x, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  // q-format product, floored
  function automatic longint fix_mul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  // one controller step: returns the drive result and advances the history
  function automatic drive_result_t compute_drive(logic [1:0] func, logic [2:0] gsel,
                                                  logic [CODE_W-1:0] rcode,
                                                  logic [CODE_W-1:0] fcode);
    longint err, ctrl, acc, p_term, d_term, gain, level, lim, sep;
    bit integrate;
    drive_result_t r;
    err = longint'($signed(gain_ref)) * longint'(rcode)
        - longint'($signed(gain_fb)) * longint'(fcode)
        + longint'($signed(err_bias));
    err = clamp_signed(err, 32);
    if (func == FUNC_P_ONLY) begin
      gain = (longint'(184 + int'(gsel)) * ONE + 50) / 100;
      ctrl = clamp_signed(fix_mul(gain, err), 48);
      acc = 0;
    end else begin
      lim = CLAMP_CODE * ONE;
      sep = longint'(sep_limit);
      p_term = fix_mul(longint'($signed(gain_p)), err);
      d_term = fix_mul(longint'($signed(gain_d)), clamp_signed(err - prev_err_q, 32));
      integrate = 1'b1;
      // separation: hold the integral on large errors
      if (func == FUNC_SEP && (err > sep || err < -sep)) integrate = 1'b0;
      // anti-windup: hold while pinned and pushing further
      if (func == FUNC_CLAMP &&
          ((last_ctrl >= lim && err > 0) || (last_ctrl <= -lim && err < 0)))
        integrate = 1'b0;
      acc = integ_acc;
      if (integrate) acc = clamp_signed(acc + fix_mul(longint'($signed(gain_i)), err), 48);
      ctrl = clamp_signed(p_term + acc + d_term, 48);
    end
    last_ctrl = ctrl;
    integ_acc = acc;
    prev_err_q = err;

    level = ctrl + longint'($signed(drive_bias));
    if (level > CODE_MAX * ONE - HALF) begin
      r.drive = CODE_W'(CODE_MAX);
      r.clip = CLIP_HIGH;
    end else if (level < HALF) begin
      r.drive = '0;
      r.clip = CLIP_LOW;
    end else begin
      r.drive = CODE_W'((level + HALF) >>> FRAC);
      r.clip = CLIP_NONE;
    end
    r.err = ERR_OUT_W'(clamp_signed(err >>> FRAC, ERR_OUT_W));
    return r;
  endfunction

  function automatic gain_set_t make_gains(logic [CFG_W-1:0] ref_gain, fb_gain, err_offset,
                                           kp, ki, kd, threshold, out_offset);
    gain_set_t g;
    g.ref_gain = ref_gain;
    g.fb_gain = fb_gain;
    g.err_offset = err_offset;
    g.kp = kp;
    g.ki = ki;
    g.kd = kd;
    g.threshold = threshold;
    g.out_offset = out_offset;
    return g;
  endfunction

  // mostly a scaled copy of the base value, sometimes negated, zero or anything
  function automatic logic [CFG_W-1:0] near_value(logic [CFG_W-1:0] base);
    int unsigned pick;
    longint v;
    pick = $urandom_range(99);
    if (pick < 12) return $urandom();
    if (pick < 17) return '0;
    v = longint'(base) * longint'($urandom_range(150, 50)) / 100;
    if (pick < 27) v = -v;
    return CFG_W'(v);
  endfunction

  // result channel backpressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    drive_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (drive_expected.size() == 0) begin
        $display("%0t unexpected result: drive_code %0d error_value %0d clip %0d",
                 $time, out_drive_code, out_error_value, out_clip);
        fail_count++;
      end else begin
        want = drive_expected.pop_front();
        if (out_drive_code !== want.drive) begin
          $display("%0t drive_code mismatch: expected %0d, got %0d",
                   $time, want.drive, out_drive_code);
          fail_count++;
        end
        if (out_error_value !== want.err) begin
          $display("%0t error_value mismatch: expected %0d, got %0d",
                   $time, $signed(want.err), out_error_value);
          fail_count++;
        end
        if (out_clip !== want.clip) begin
          $display("%0t clip mismatch: expected %0d, got %0d", $time, want.clip, out_clip);
          fail_count++;
        end
      end
    end
  end

  // present one request, wait for acceptance, record its prediction
  task automatic send_sample(logic [1:0] func, logic [2:0] gsel,
                             logic [CODE_W-1:0] rcode, logic [CODE_W-1:0] fcode);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_gain_select <= gsel;
    in_ref_code <= rcode;
    in_fb_code <= fcode;
    do @(posedge clk); while (!in_ready);
    drive_expected.push_back(compute_drive(func, gsel, rcode, fcode));
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain;
    in_valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_REF_GAIN:   gain_ref = data;
      REG_FB_GAIN:    gain_fb = data;
      REG_ERR_OFFSET: err_bias = data;
      REG_KP:         gain_p = data;
      REG_KI:         gain_i = data;
      REG_KD:         gain_d = data;
      REG_THRESHOLD:  sep_limit = data[THR_W-1:0];
      REG_OUT_OFFSET: drive_bias = data;
      default: ;
    endcase
  endtask

  // reprogram every register once the block is idle
  task automatic load_gains(gain_set_t g);
    drain();
    write_reg(REG_REF_GAIN, g.ref_gain);
    write_reg(REG_FB_GAIN, g.fb_gain);
    write_reg(REG_ERR_OFFSET, g.err_offset);
    write_reg(REG_KP, g.kp);
    write_reg(REG_KI, g.ki);
    write_reg(REG_KD, g.kd);
    write_reg(REG_THRESHOLD, g.threshold);
    write_reg(REG_OUT_OFFSET, g.out_offset);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // reset settings, field extremes and the p-only, PID and clamp modes
  task automatic test_reset_defaults;
    send_sample(FUNC_P_ONLY, 3'd0, '0, '0);
    send_sample(FUNC_P_ONLY, 3'd7, '1, '0);
    send_sample(FUNC_PID, 3'd0, '0, '1);
    send_sample(FUNC_CLAMP, 3'd2, 12'd2048, 12'd1000);
  endtask

  // error, derivative, integral and control saturation at both rails
  task automatic test_saturation;
    load_gains(make_gains(Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    repeat (2) send_sample(FUNC_PID, 3'd0, '1, '0);
    send_sample(FUNC_PID, 3'd0, '0, '1);
    send_sample(FUNC_CLAMP, 3'd0, '0, '1);
    load_gains(make_gains(Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, '0, Q_MIN));
    send_sample(FUNC_SEP, 3'd0, '1, '0);
    send_sample(FUNC_P_ONLY, 3'd7, '0, '1);
  endtask

  // errors at and around the separation limit, top write-data bit set
  task automatic test_separation;
    load_gains(make_gains(Q_ONE, Q_ONE, '0, Q_ONE, Q_ONE, Q_ONE, Q_MIN | Q_ONE,
                          RST_OUT_OFFSET));
    send_sample(FUNC_SEP, 3'd0, 12'd100, 12'd100);
    send_sample(FUNC_SEP, 3'd0, 12'd101, 12'd100);
    send_sample(FUNC_SEP, 3'd0, 12'd99, 12'd100);
    send_sample(FUNC_SEP, 3'd0, 12'd102, 12'd100);
    send_sample(FUNC_SEP, 3'd0, 12'd98, 12'd100);
  endtask

  // control driven onto the clamp level in both directions
  task automatic test_clamp;
    load_gains(make_gains(Q_ONE, Q_ONE, '0, 32'h07FF_0000, Q_ONE, '0, {1'b0, RST_THRESHOLD},
                          RST_OUT_OFFSET));
    send_sample(FUNC_P_ONLY, 3'd0, 12'd100, 12'd100);
    send_sample(FUNC_CLAMP, 3'd0, 12'd101, 12'd100);
    send_sample(FUNC_CLAMP, 3'd0, 12'd101, 12'd100);
    send_sample(FUNC_CLAMP, 3'd0, 12'd100, 12'd100);
    send_sample(FUNC_CLAMP, 3'd0, 12'd99, 12'd100);
    send_sample(FUNC_CLAMP, 3'd0, 12'd99, 12'd100);
  endtask

  // output just below, on and above both clip thresholds
  task automatic test_output_bounds;
    load_gains(make_gains(32'd1, 32'h0FFE_0000, '0, Q_ONE, '0, '0, {1'b0, RST_THRESHOLD},
                          32'd268335104));
    send_sample(FUNC_P_ONLY, 3'd0, '0, '0);
    send_sample(FUNC_PID, 3'd0, 12'd2047, 12'd0);
    send_sample(FUNC_PID, 3'd0, 12'd2048, 12'd0);
    send_sample(FUNC_PID, 3'd0, 12'd2049, 12'd0);
    send_sample(FUNC_PID, 3'd0, 12'd2047, 12'd1);
    send_sample(FUNC_PID, 3'd0, 12'd2048, 12'd1);
  endtask

  // mostly a tracking loop with small errors, mixed with arbitrary samples
  task automatic run_traffic(int count);
    logic [1:0] func;
    int walk, step;
    longint track, fb_scale;
    func = 2'($urandom_range(3));
    walk = $urandom_range(4095);
    repeat (count) begin
      if ($urandom_range(15) == 0) func = 2'($urandom_range(3));
      if ($urandom_range(99) < 25) begin
        send_sample(2'($urandom), 3'($urandom), CODE_W'($urandom), CODE_W'($urandom));
      end else begin
        step = int'($urandom_range(128)) - 64;
        walk = walk + step;
        if (walk < 0) walk = 0;
        if (walk > 4095) walk = 4095;
        fb_scale = longint'($signed(gain_fb));
        if (fb_scale == 0) track = $urandom_range(4095);
        else track = (longint'($signed(gain_ref)) * walk + longint'($signed(err_bias)))
                     / fb_scale;
        track = track + int'($urandom_range(16)) - 8;
        if (track < 0) track = 0;
        if (track > 4095) track = 4095;
        send_sample(func, 3'($urandom), CODE_W'(walk), CODE_W'(track));
      end
    end
  endtask

  // random settings (the reset settings first) under each idling pattern
  task automatic test_random_traffic;
    int send_mix[4] = '{0, 51, 0, 13};
    int recv_mix[4] = '{0, 0, 51, 13};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_mix[ph];
      recv_stall_pct = recv_mix[ph];
      for (int s = 0; s < 3; s++) begin
        if (ph == 0 && s == 0)
          load_gains(make_gains(RST_REF_GAIN, RST_FB_GAIN, RST_ERR_OFFSET, RST_KP, RST_KI,
                                RST_KD, {1'b0, RST_THRESHOLD}, RST_OUT_OFFSET));
        else
          load_gains(make_gains(near_value(RST_REF_GAIN), near_value(RST_FB_GAIN),
                                near_value(RST_ERR_OFFSET), near_value(RST_KP),
                                near_value(RST_KI), near_value(RST_KD),
                                near_value({1'b0, RST_THRESHOLD}),
                                near_value(RST_OUT_OFFSET)));
        run_traffic(62);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_saturation();
    test_separation();
    test_clamp();
    test_output_bounds();
    test_random_traffic();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && drive_expected.size() == 0)
      $display("PASS pid_with_integral_separation");
    else
      $display("FAIL pid_with_integral_separation");
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("FAIL pid_with_integral_separation");
    $finish;
  end

endmodule
